/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define SAWCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define SAWCP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SAWCP_ASSERT(label, clk, rst_n, prop, msg)
`define SAWCP_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* src/sawcp_pkg.sv */
// ----------------------------------------------------------------------------
// sawcp_pkg
// Shared types and constants of the set-associative write-back cache
// directory: beat structs, line status codes, controller states and the
// command/status bundle between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sawcp_pkg;

    localparam int ADDR_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int OUT_WAY_W = 2;
    localparam int LINE_ST_W = 2;

    // Access commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Line status codes; code 3 behaves like dirty
    localparam logic [LINE_ST_W-1:0] ST_INVALID = 2'd0;
    localparam logic [LINE_ST_W-1:0] ST_CLEAN   = 2'd1;
    localparam logic [LINE_ST_W-1:0] ST_DIRTY   = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] block_number;
    } t_in_beat;

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic                 writeback;
        logic [ADDR_W-1:0]    victim_block;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Kind of row write-back at the end of an access
    typedef enum logic [1:0] {
        CM_NONE,
        CM_STAMP,
        CM_WRITE
    } t_commit;

    typedef struct packed {
        logic    accept;
        logic    clear_wr;
        logic    scan_init;
        logic    scan_step;
        logic    from_scan;
        t_commit commit;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_write;
        logic hit;
        logic any_invalid;
        logic clear_last;
        logic scan_last;
    } t_dp_sts;

endpackage

/* src/sawcp_dp.sv */
// ----------------------------------------------------------------------------
// sawcp_dp
// Datapath: set-wide tag, status and stamp memories, access counter,
// parallel tag compare, LRU scan registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sawcp_dp
    import sawcp_pkg::*;
#(
    parameter int NUM_SETS        = 1024,
    parameter int NUM_WAYS        = 4,
    parameter int BLOCKS_PER_PAGE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_beat o_out_data
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int OFF_W = $clog2(BLOCKS_PER_PAGE);
    localparam int TAG_W = ADDR_W - OFF_W - SET_W;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    // Row memories, one row per set
    logic [NUM_WAYS-1:0][TAG_W-1:0]     r_tag_mem   [NUM_SETS];
    logic [NUM_WAYS-1:0][LINE_ST_W-1:0] r_st_mem    [NUM_SETS];
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   r_stamp_mem [NUM_SETS];

    logic [NUM_WAYS-1:0][TAG_W-1:0]     r_rd_tag;
    logic [NUM_WAYS-1:0][LINE_ST_W-1:0] r_rd_st;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   r_rd_stamp;

    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic               r_is_write;
    logic [STAMP_W-1:0] r_acc_cnt;
    logic [SET_W-1:0]   r_clr_addr;

    logic [WAY_W-1:0]   r_scan_idx;
    logic               r_cl_found;
    logic [STAMP_W-1:0] r_cl_age;
    logic [WAY_W-1:0]   r_cl_way;
    logic               r_dt_found;
    logic [STAMP_W-1:0] r_dt_age;
    logic [WAY_W-1:0]   r_dt_way;

    t_out_beat r_out;

    logic [ADDR_W-1:0]    w_page;
    logic [SET_W-1:0]     w_in_set;
    logic [TAG_W-1:0]     w_in_tag;
    logic [NUM_WAYS-1:0]  w_hit_vec;
    logic [NUM_WAYS-1:0]  w_inv_vec;
    logic [WAY_W-1:0]     w_hit_way;
    logic [WAY_W-1:0]     w_inv_way;
    logic                 w_hit;
    logic [LINE_ST_W-1:0] w_scan_st;
    logic [STAMP_W-1:0]   w_scan_age;
    logic [WAY_W-1:0]     w_lk_way;
    logic [WAY_W-1:0]     w_sc_way;
    logic [WAY_W-1:0]     w_cm_way;
    logic                 w_wb;
    logic [ADDR_W-1:0]    w_victim;

    logic [NUM_WAYS-1:0][TAG_W-1:0]     w_wr_tag;
    logic [NUM_WAYS-1:0][LINE_ST_W-1:0] w_wr_st;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   w_wr_stamp;

    // Split block number into set and tag
    assign w_page   = i_in_data.block_number >> OFF_W;
    assign w_in_set = w_page[SET_W-1:0];
    assign w_in_tag = TAG_W'(w_page >> SET_W);

    // Latch the access and read its set row
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set      <= w_in_set;
            r_tag      <= w_in_tag;
            r_is_write <= (i_in_data.cmd == CMD_WRITE);
            r_rd_tag   <= r_tag_mem[w_in_set];
            r_rd_st    <= r_st_mem[w_in_set];
            r_rd_stamp <= r_stamp_mem[w_in_set];
        end
    end

    // Advance access counter and clear address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt  <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_acc_cnt <= r_acc_cnt + STAMP_W'(1);
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
        end
    end

    // Compare tags of valid lines, find first invalid way
    always_comb begin
        w_hit_vec = '0;
        w_inv_vec = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_inv_vec[w] = (r_rd_st[w] == ST_INVALID);
            w_hit_vec[w] = !w_inv_vec[w] && (r_rd_tag[w] == r_tag);
        end
    end

    always_comb begin
        w_hit_way = '0;
        w_inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) begin
                w_hit_way = WAY_W'(w);
            end
            if (w_inv_vec[w]) begin
                w_inv_way = WAY_W'(w);
            end
        end
    end

    assign w_hit = |w_hit_vec;

    // One way per scan step: track oldest clean and oldest dirty line
    assign w_scan_st  = r_rd_st[r_scan_idx];
    assign w_scan_age = r_acc_cnt - r_rd_stamp[r_scan_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cl_found <= 1'b0;
            r_dt_found <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_scan_idx <= '0;
            r_cl_found <= 1'b0;
            r_dt_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + WAY_W'(1);
            if (w_scan_st == ST_CLEAN) begin
                if (!r_cl_found || (w_scan_age > r_cl_age)) begin
                    r_cl_found <= 1'b1;
                end
            end else if (w_scan_st != ST_INVALID) begin
                if (!r_dt_found || (w_scan_age > r_dt_age)) begin
                    r_dt_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            if (w_scan_st == ST_CLEAN) begin
                if (!r_cl_found || (w_scan_age > r_cl_age)) begin
                    r_cl_age <= w_scan_age;
                    r_cl_way <= r_scan_idx;
                end
            end else if (w_scan_st != ST_INVALID) begin
                if (!r_dt_found || (w_scan_age > r_dt_age)) begin
                    r_dt_age <= w_scan_age;
                    r_dt_way <= r_scan_idx;
                end
            end
        end
    end

    // Pick the way to update and the victim
    assign w_lk_way = w_hit ? w_hit_way : w_inv_way;
    assign w_sc_way = r_cl_found ? r_cl_way : r_dt_way;
    assign w_cm_way = i_cmd.from_scan ? w_sc_way : w_lk_way;
    assign w_wb     = i_cmd.from_scan && !r_cl_found;
    assign w_victim = ADDR_W'({r_rd_tag[r_dt_way], r_set}) << OFF_W;

    // Build the updated row
    always_comb begin
        w_wr_tag             = r_rd_tag;
        w_wr_st              = r_rd_st;
        w_wr_stamp           = r_rd_stamp;
        w_wr_tag[w_cm_way]   = r_tag;
        w_wr_st[w_cm_way]    = ST_DIRTY;
        w_wr_stamp[w_cm_way] = r_acc_cnt;
    end

    // Write rows: clearing pass, full line update or stamp refresh
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_st_mem[r_clr_addr] <= {NUM_WAYS{ST_INVALID}};
        end else if (i_cmd.commit == CM_WRITE) begin
            r_tag_mem[r_set]   <= w_wr_tag;
            r_st_mem[r_set]    <= w_wr_st;
            r_stamp_mem[r_set] <= w_wr_stamp;
        end else if (i_cmd.commit == CM_STAMP) begin
            r_stamp_mem[r_set] <= w_wr_stamp;
        end
    end

    // Load result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.hit          <= w_hit;
            r_out.way          <= (r_is_write || w_hit) ? OUT_WAY_W'(w_cm_way) : '0;
            r_out.writeback    <= w_wb;
            r_out.victim_block <= w_wb ? w_victim : '0;
        end
    end

    assign o_out_data = r_out;

    assign o_sts.is_write    = r_is_write;
    assign o_sts.hit         = w_hit;
    assign o_sts.any_invalid = |w_inv_vec;
    assign o_sts.clear_last  = (r_clr_addr == SET_W'(NUM_SETS - 1));
    assign o_sts.scan_last   = (r_scan_idx == WAY_W'(NUM_WAYS - 1));

    `SAWCP_ASSERT(a_hit_unique, i_clk, i_rst_n, i_cmd.out_load |-> $onehot0(w_hit_vec), "page held in two ways of one set")
    `SAWCP_ASSERT(a_scan_found, i_clk, i_rst_n, (i_cmd.commit == CM_WRITE && i_cmd.from_scan) |-> (r_cl_found || r_dt_found), "eviction without a candidate way")
    `SAWCP_ASSERT_NEVER(a_clear_excl, i_clk, i_rst_n, i_cmd.clear_wr && (i_cmd.accept || i_cmd.commit != CM_NONE), "access during clearing pass")

endmodule

/* src/sawcp_ctrl.sv */
// ----------------------------------------------------------------------------
// sawcp_ctrl
// Controller: sequences the clearing pass, lookup, LRU scan and commit of
// each access and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sawcp_ctrl
    import sawcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Result register can take a beat this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.clear_wr  = 1'b0;
        o_cmd.scan_init = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.from_scan = 1'b0;
        o_cmd.commit    = CM_NONE;
        o_cmd.out_load  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                priority if (i_sts.is_write && !i_sts.hit && !i_sts.any_invalid) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.is_write) begin
                        o_cmd.commit = CM_WRITE;
                    end else if (i_sts.hit) begin
                        o_cmd.commit = CM_STAMP;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.from_scan = 1'b1;
                    o_cmd.commit    = CM_WRITE;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // Hold the result until taken
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `SAWCP_ASSERT(a_load_free, i_clk, i_rst_n, o_cmd.out_load |-> w_out_free, "result beat overwritten while stalled")
    `SAWCP_ASSERT(a_accept_lookup, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == S_LOOKUP), "accepted beat not looked up")
    `SAWCP_ASSERT(a_load_valid, i_clk, i_rst_n, o_cmd.out_load |=> o_out_valid, "loaded result not presented")

endmodule

/* src/set_assoc_write_cache_policy.sv */
// ----------------------------------------------------------------------------
// set_assoc_write_cache_policy
// Page-granular set-associative write-back cache directory with LRU victim
// choice: read hits refresh stamps, writes allocate and report evictions.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Beat
//   -------  ---------  -----------------------  -----------------------------
//   in       input      i_in_valid / o_in_stall  cmd, block_number
//   out      output     o_out_valid/i_out_stall  hit, way, writeback, victim
//
// - Reads, write hits and writes into an invalid way: accept with set-row
//   read, then lookup and row write.
// - Writes into a full set: accept, lookup, LRU scan, then commit; the LRU
//   scan inspects one way per cycle from the registered row.
// - After reset a clearing pass over all NUM_SETS sets marks all lines
//   invalid; o_in_stall is high during it.
// - A held result beat in the output register stalls only the final step of
//   the next access.
//
`timescale 1ns / 1ps

module set_assoc_write_cache_policy
    import sawcp_pkg::*;
#(
    parameter int NUM_SETS        = 1024,
    parameter int NUM_WAYS        = 4,
    parameter int BLOCKS_PER_PAGE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Access sequencer
    sawcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Directory memories and decision logic
    sawcp_dp #(
        .NUM_SETS        (NUM_SETS),
        .NUM_WAYS        (NUM_WAYS),
        .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule
